// File: src/mcr_pkg.sv
package mcr_pkg;

    // Range limits of the rasterizer
    localparam int unsigned MAX_RADIUS = 4095;
    localparam int unsigned MAX_CANVAS = 4096;

    // Field widths
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned PIXEL_W  = 17;
    localparam int unsigned RADIUS_W = 12;
    localparam int unsigned COLOR_W  = 32;
    localparam int unsigned CANVAS_W = 13;
    localparam int unsigned ERR_W    = 15;
    localparam int unsigned IDX_W    = 3;

    // Operation codes of an input transaction
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Last point of one step
    localparam logic [IDX_W-1:0] LAST_POINT = 3'd7;

    // Snapshot of one step, handed from the state block to the emitter
    typedef struct packed {
        logic                       dead;
        logic                       fin;
        logic [RADIUS_W-1:0]        x;
        logic [RADIUS_W-1:0]        y;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic [COLOR_W-1:0]         color;
    } t_job;

    // Clamp a canvas register to the largest supported canvas
    function automatic logic [CANVAS_W-1:0] canvas_bound(input logic [CANVAS_W-1:0] reg_val);
        logic [CANVAS_W-1:0] lim;
        lim = CANVAS_W'(MAX_CANVAS);
        return (reg_val > lim) ? lim : reg_val;
    endfunction

    // Clamp a radius to the largest supported radius
    function automatic logic [RADIUS_W-1:0] radius_bound(input logic [RADIUS_W-1:0] rad);
        logic [RADIUS_W:0] lim;
        lim = (RADIUS_W+1)'(MAX_RADIUS);
        return ({1'b0, rad} > lim) ? lim[RADIUS_W-1:0] : rad;
    endfunction

endpackage

// File: src/mcr_state.sv
module mcr_state import mcr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic                       i_opcode,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic [RADIUS_W-1:0]        i_radius,
    input  logic [COLOR_W-1:0]         i_color,
    output t_job                       o_job
);

    logic [RADIUS_W-1:0]       r_x, n_x;
    logic [RADIUS_W-1:0]       r_y, n_y;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic [COLOR_W-1:0]        r_color;
    logic                      r_active, n_active;

    logic                      w_neg;
    logic signed [13:0]        w_y1;
    logic signed [13:0]        w_x1;
    logic signed [13:0]        w_diff;
    logic signed [15:0]        w_err16;
    logic signed [15:0]        w_err_step;
    logic                      w_done;
    logic [RADIUS_W-1:0]       w_rad;

    // Advance the decision variable by one midpoint step
    always_comb begin
        w_neg   = r_err[ERR_W-1];
        w_err16 = {r_err[ERR_W-1], r_err};
        w_y1    = $signed({2'b00, r_y}) + 14'sd1;
        w_x1    = w_neg ? $signed({2'b00, r_x}) : $signed({2'b00, r_x}) - 14'sd1;
        w_diff  = w_y1 - w_x1 + 14'sd1;
        if (w_neg) begin
            w_err_step = w_err16 + {w_y1[13], w_y1, 1'b0} + 16'sd1;
        end else begin
            w_err_step = w_err16 + {w_diff[13], w_diff, 1'b0};
        end
        w_done = (w_x1 < w_y1);
    end

    assign w_rad = radius_bound(i_radius);

    // Select the next circle state
    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_err    = r_err;
        n_active = r_active;
        if (i_acc) begin
            if (i_opcode == OP_START) begin
                n_x      = w_rad;
                n_y      = '0;
                n_err    = ERR_W'(15'sd1 - $signed({3'b000, w_rad}));
                n_active = 1'b1;
            end else if (r_active) begin
                if (w_done) begin
                    n_x      = '0;
                    n_y      = '0;
                    n_err    = '0;
                    n_active = 1'b0;
                end else begin
                    n_x   = w_x1[RADIUS_W-1:0];
                    n_y   = w_y1[RADIUS_W-1:0];
                    n_err = w_err_step[ERR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_err    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_err    <= n_err;
            r_active <= n_active;
            if (i_acc && i_opcode == OP_START) begin
                r_cx    <= i_center_x;
                r_cy    <= i_center_y;
                r_color <= i_color;
            end
        end
    end

    // Snapshot of the current step for the emitter
    always_comb begin
        o_job.dead  = !r_active;
        o_job.fin   = w_done;
        o_job.x     = r_x;
        o_job.y     = r_y;
        o_job.cx    = r_cx;
        o_job.cy    = r_cy;
        o_job.color = r_color;
    end

endmodule

// File: src/mcr_emit.sv
module mcr_emit import mcr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_load,
    input  t_job                       i_job,
    input  logic [CANVAS_W-1:0]        i_width,
    input  logic [CANVAS_W-1:0]        i_height,
    output logic                       o_busy,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [PIXEL_W-1:0]  o_pixel_x,
    output logic signed [PIXEL_W-1:0]  o_pixel_y,
    output logic [COLOR_W-1:0]         o_pixel_color,
    output logic                       o_inside_res,
    output logic                       o_last,
    output logic                       o_finished
);

    t_job                       r_job;
    logic                       r_busy;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_out_valid;
    logic signed [PIXEL_W-1:0]  r_px;
    logic signed [PIXEL_W-1:0]  r_py;
    logic [COLOR_W-1:0]         r_color;
    logic                       r_inside;
    logic                       r_last;
    logic                       r_fin;

    logic                       w_out_free;
    logic                       w_adv;
    logic                       w_is_last;
    logic [RADIUS_W-1:0]        w_a;
    logic [RADIUS_W-1:0]        w_b;
    logic                       w_neg_x;
    logic                       w_neg_y;
    logic signed [PIXEL_W-1:0]  w_cx;
    logic signed [PIXEL_W-1:0]  w_cy;
    logic signed [PIXEL_W-1:0]  w_da;
    logic signed [PIXEL_W-1:0]  w_db;
    logic signed [PIXEL_W-1:0]  n_px;
    logic signed [PIXEL_W-1:0]  n_py;
    logic [PIXEL_W-1:0]         w_bw;
    logic [PIXEL_W-1:0]         w_bh;
    logic                       n_inside;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_busy && w_out_free;
    assign w_is_last  = r_job.dead || (r_idx == LAST_POINT);
    assign o_busy     = r_busy && !(w_adv && w_is_last);

    // Form the octant point for the current index
    always_comb begin
        w_a     = r_idx[0] ? r_job.y : r_job.x;
        w_b     = r_idx[0] ? r_job.x : r_job.y;
        w_neg_x = (r_idx[2] != r_idx[1]);
        w_neg_y = r_idx[2];
        w_cx    = {r_job.cx[COORD_W-1], r_job.cx};
        w_cy    = {r_job.cy[COORD_W-1], r_job.cy};
        w_da    = $signed({{(PIXEL_W-RADIUS_W){1'b0}}, w_a});
        w_db    = $signed({{(PIXEL_W-RADIUS_W){1'b0}}, w_b});
        n_px    = w_neg_x ? (w_cx - w_da) : (w_cx + w_da);
        n_py    = w_neg_y ? (w_cy - w_db) : (w_cy + w_db);
        w_bw    = {{(PIXEL_W-CANVAS_W){1'b0}}, canvas_bound(i_width)};
        w_bh    = {{(PIXEL_W-CANVAS_W){1'b0}}, canvas_bound(i_height)};
        n_inside = !n_px[PIXEL_W-1] && !n_py[PIXEL_W-1] &&
                   (unsigned'(n_px) < w_bw) && (unsigned'(n_py) < w_bh);
    end

    // Step through the points of the held job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_job_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_adv) begin
            if (w_is_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_load) begin
            r_job <= i_job;
        end
    end

    // Hold the result register until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_job.dead) begin
                r_px     <= '0;
                r_py     <= '0;
                r_color  <= '0;
                r_inside <= 1'b0;
                r_last   <= 1'b1;
                r_fin    <= 1'b1;
            end else begin
                r_px     <= n_px;
                r_py     <= n_py;
                r_color  <= r_job.color;
                r_inside <= n_inside;
                r_last   <= w_is_last;
                r_fin    <= w_is_last && r_job.fin;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_color;
    assign o_inside_res  = r_inside;
    assign o_last        = r_last;
    assign o_finished    = r_fin;

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_load |-> (!r_busy || (w_adv && w_is_last)))
        else $error("job loaded while emitter still holds points");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == '0))
        else $error("point index nonzero while idle");

    a_keep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_is_last) |=> r_busy)
        else $error("emitter dropped a job before its last point");

    a_fin_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fin) |-> r_last)
        else $error("finished flag set on a point that is not last");
`endif

endmodule

// File: src/midpoint_circle_rasterizer_top.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    opcode, center_x, center_y, radius, color
// output    out        o_out_valid / i_out_stall  pixel_x, pixel_y, pixel_color, inside_res,
//                                                 last, finished
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A start transaction yields nothing. A step transaction yields eight points, one per cycle
// through the output register while the output does not stall. The point emitter paces steps:
// it takes the next one as it emits its last point. A step on an idle circle yields one point.
// Reset is synchronous, active low, and takes effect at once; no clearing pass.
// A stalled output holds its point and the input stalls once the emitter is full.
module midpoint_circle_rasterizer_top import mcr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_opcode,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic [RADIUS_W-1:0]        i_radius,
    input  logic [COLOR_W-1:0]         i_color,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [CANVAS_W-1:0]        i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [PIXEL_W-1:0]  o_pixel_x,
    output logic signed [PIXEL_W-1:0]  o_pixel_y,
    output logic [COLOR_W-1:0]         o_pixel_color,
    output logic                       o_inside_res,
    output logic                       o_last,
    output logic                       o_finished
);

    logic [CANVAS_W-1:0] r_width;
    logic [CANVAS_W-1:0] r_height;
    logic                w_acc;
    logic                w_job_load;
    logic                w_busy;
    t_job                w_job;

    // Capture configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CANVAS_W'(640);
            r_height <= CANVAS_W'(480);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    // Accept input while the emitter can take a new job
    assign o_in_stall = w_busy;
    assign w_acc      = i_in_valid && !w_busy;
    assign w_job_load = w_acc && (i_opcode == OP_STEP);

    mcr_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_acc),
        .i_opcode   (i_opcode),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_color    (i_color),
        .o_job      (w_job)
    );

    mcr_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_load    (w_job_load),
        .i_job         (w_job),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_busy        (w_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_inside_res  (o_inside_res),
        .o_last        (o_last),
        .o_finished    (o_finished)
    );

endmodule

// File: verif/midpoint_circle_rasterizer_top_tb.sv
module midpoint_circle_rasterizer_top_tb import mcr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;

    // One expected point on the output channel
    typedef struct {
        logic signed [PIXEL_W-1:0] px;
        logic signed [PIXEL_W-1:0] py;
        logic [COLOR_W-1:0]        color;
        logic                      in_canvas;
        logic                      last;
        logic                      fin;
    } t_point;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_opcode = OP_START;
    logic signed [COORD_W-1:0]  i_center_x = '0;
    logic signed [COORD_W-1:0]  i_center_y = '0;
    logic [RADIUS_W-1:0]        i_radius = '0;
    logic [COLOR_W-1:0]         i_color = '0;
    logic                       i_cfg_we = 1'b0;
    logic                       i_cfg_idx = CFG_WIDTH;
    logic [CANVAS_W-1:0]        i_cfg_data = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [PIXEL_W-1:0]  o_pixel_x;
    logic signed [PIXEL_W-1:0]  o_pixel_y;
    logic [COLOR_W-1:0]         o_pixel_color;
    logic                       o_inside_res;
    logic                       o_last;
    logic                       o_finished;

    // Circle tracker: mirror of the block state and canvas registers
    logic [CANVAS_W-1:0]        canvas_w = 13'd640;
    logic [CANVAS_W-1:0]        canvas_h = 13'd480;
    logic signed [COORD_W-1:0]  ctr_x = '0;
    logic signed [COORD_W-1:0]  ctr_y = '0;
    logic [COLOR_W-1:0]         ink = '0;
    int                         arc_x = 0;
    int                         arc_y = 0;
    int                         arc_err = 0;
    bit                         drawing = 1'b0;

    t_point pending_points[$];

    bit in_burst = 1'b0;
    bit out_burst = 1'b0;
    int out_hold = 0;
    int n_errors = 0;
    int n_items = 0;
    int n_starts = 0;
    int n_points = 0;
    int n_settings = 0;
    int n_cycles = 0;

    midpoint_circle_rasterizer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_color       (i_color),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_inside_res  (o_inside_res),
        .o_last        (o_last),
        .o_finished    (o_finished)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Clip bound of a canvas register: oversized values act as the largest canvas
    function automatic int clip_limit(input logic [CANVAS_W-1:0] v);
        return (v > MAX_CANVAS) ? int'(MAX_CANVAS) : int'(v);
    endfunction

    // Queue one plotted point, flagged by the current canvas
    function automatic void push_point(input int x, input int y, input bit lst, input bit fin);
        t_point p;
        p.px        = PIXEL_W'(x);
        p.py        = PIXEL_W'(y);
        p.color     = ink;
        p.in_canvas = (x >= 0) && (y >= 0) && (x < clip_limit(canvas_w))
                      && (y < clip_limit(canvas_h));
        p.last      = lst;
        p.fin       = fin;
        pending_points.push_back(p);
    endfunction

    // Predict the points one accepted transaction produces and advance the circle
    task automatic plot_circle(input logic op, input logic signed [COORD_W-1:0] cx_in,
                               input logic signed [COORD_W-1:0] cy_in,
                               input logic [RADIUS_W-1:0] rad, input logic [COLOR_W-1:0] col);
        int     x0, y0, cx, cy;
        int     px[8];
        int     py[8];
        t_point idle_pt;
        if (op == OP_START) begin
            ctr_x   = cx_in;
            ctr_y   = cy_in;
            ink     = col;
            arc_x   = (rad > MAX_RADIUS) ? int'(MAX_RADIUS) : int'(rad);
            arc_y   = 0;
            arc_err = 1 - arc_x;
            drawing = 1'b1;
            n_starts++;
        end else if (!drawing) begin
            // no circle in progress: a single blank closing point
            idle_pt = '{px: '0, py: '0, color: '0, in_canvas: 1'b0, last: 1'b1, fin: 1'b1};
            pending_points.push_back(idle_pt);
        end else begin
            x0 = arc_x;
            y0 = arc_y;
            cx = ctr_x;
            cy = ctr_y;
            px = '{cx + x0, cx + y0, cx - x0, cx - y0, cx - x0, cx - y0, cx + x0, cx + y0};
            py = '{cy + y0, cy + x0, cy + y0, cy + x0, cy - y0, cy - x0, cy - y0, cy - x0};
            // advance the midpoint decision
            arc_y++;
            if (arc_err < 0) begin
                arc_err += 2 * arc_y + 1;
            end else begin
                arc_x--;
                arc_err += 2 * (arc_y - arc_x + 1);
            end
            if (arc_x < arc_y) begin
                drawing = 1'b0;
                arc_x   = 0;
                arc_y   = 0;
                arc_err = 0;
            end
            for (int k = 0; k < 8; k++) begin
                push_point(px[k], py[k], k == 7, (k == 7) && !drawing);
            end
        end
    endtask

    // Send one transaction after a random gap and predict it once accepted
    task automatic send_item(input logic op, input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy,
                             input logic [RADIUS_W-1:0] rad, input logic [COLOR_W-1:0] col);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= rad;
        i_color    <= col;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        plot_circle(op, cx, cy, rad, col);
        n_items++;
    endtask

    task automatic start_circle(input int cx, input int cy, input int rad,
                                input logic [COLOR_W-1:0] col);
        send_item(OP_START, COORD_W'(cx), COORD_W'(cy), RADIUS_W'(rad), col);
    endtask

    // Step with junk in the unused fields
    task automatic step_circle();
        send_item(OP_STEP, COORD_W'($urandom), COORD_W'($urandom), RADIUS_W'($urandom),
                  $urandom);
    endtask

    // Drop valid, drain all expected points, then let the block settle
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both canvas registers while the block is idle
    task automatic set_canvas(input logic [CANVAS_W-1:0] w, input logic [CANVAS_W-1:0] h);
        quiesce();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        canvas_w = w;
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        canvas_h = h;
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic test_idle_step();
        step_circle();
    endtask

    task automatic test_zero_radius();
        start_circle(100, 100, 0, $urandom);
        step_circle();
        step_circle();
    endtask

    // Points straddling both canvas edges under the reset canvas
    task automatic test_canvas_edges();
        start_circle(639, 479, 1, 32'h12345678);
        step_circle();
        start_circle(0, 0, 1, 32'h87654321);
        step_circle();
    endtask

    // Extreme centers, radius and colors; restart while a circle is open
    task automatic test_extreme_fields();
        start_circle(-32768, -32768, 4095, 32'h0000_0000);
        step_circle();
        step_circle();
        start_circle(32767, 32767, 4095, 32'hFFFF_FFFF);
        step_circle();
        step_circle();
    endtask

    task automatic test_full_circle();
        start_circle(320, 240, 12, $urandom);
        while (drawing) step_circle();
        step_circle();
    endtask

    // Tiny, empty and oversized canvases
    task automatic test_canvas_settings();
        set_canvas(13'd1, 13'd1);
        start_circle(0, 0, 0, $urandom);
        step_circle();
        set_canvas(13'd0, 13'd0);
        start_circle(0, 0, 0, $urandom);
        step_circle();
        set_canvas(13'd8191, 13'd4096);
        start_circle(4095, 4095, 1, $urandom);
        step_circle();
        set_canvas(13'd4096, 13'd8191);
        start_circle(4096, 0, 2, $urandom);
        step_circle();
    endtask

    // Mostly complete circles with random content, some cut short, some noise
    task automatic random_circle();
        int                        cut;
        logic signed [COORD_W-1:0] cx, cy;
        logic [RADIUS_W-1:0]       rad;
        in_burst  = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      RADIUS_W'($urandom), $urandom);
            return;
        end
        if ($urandom_range(0, 4) == 0) begin
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
        end else begin
            cx = COORD_W'(int'($urandom_range(0, clip_limit(canvas_w) + 40)) - 20);
            cy = COORD_W'(int'($urandom_range(0, clip_limit(canvas_h) + 40)) - 20);
        end
        rad = ($urandom_range(0, 7) == 0) ? RADIUS_W'($urandom)
                                          : RADIUS_W'($urandom_range(0, 16));
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 16;
        send_item(OP_START, cx, cy, rad, $urandom);
        for (int n = 0; drawing && n < cut; n++) begin
            step_circle();
        end
        if ($urandom_range(0, 2) == 0) begin
            step_circle();
        end
    endtask

    task automatic test_random_circles();
        logic [CANVAS_W-1:0] w, h;
        int                  goal;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    w = CANVAS_W'($urandom_range(1, 64));
                    h = CANVAS_W'($urandom_range(1, 64));
                end
                1: begin
                    w = 13'd640;
                    h = 13'd480;
                end
                2: begin
                    w = CANVAS_W'($urandom);
                    h = CANVAS_W'($urandom);
                end
                default: begin
                    w = 13'd4096;
                    h = 13'd4096;
                end
            endcase
            set_canvas(w, h);
            goal = n_items + 12;
            while (n_items < goal) random_circle();
        end
        in_burst  = 1'b0;
        out_burst = 1'b0;
    endtask

    // Check each output transaction against the oldest predicted point
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_points++;
            if (pending_points.size() == 0) begin
                $error("unexpected point: x=%0d y=%0d last=%0b", o_pixel_x, o_pixel_y, o_last);
                n_errors++;
            end else begin
                want = pending_points.pop_front();
                if (o_pixel_x !== want.px) begin
                    $error("pixel_x: expected %0d, got %0d", want.px, o_pixel_x);
                    n_errors++;
                end
                if (o_pixel_y !== want.py) begin
                    $error("pixel_y: expected %0d, got %0d", want.py, o_pixel_y);
                    n_errors++;
                end
                if (o_pixel_color !== want.color) begin
                    $error("pixel_color: expected %h, got %h", want.color, o_pixel_color);
                    n_errors++;
                end
                if (o_inside_res !== want.in_canvas) begin
                    $error("inside_res: expected %0b, got %0b", want.in_canvas, o_inside_res);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    n_errors++;
                end
                if (o_finished !== want.fin) begin
                    $error("finished: expected %0b, got %0b", want.fin, o_finished);
                    n_errors++;
                end
            end
            out_hold = out_burst ? 0 : $urandom_range(0, 19);
        end else if (out_hold != 0) begin
            out_hold--;
        end
        i_out_stall <= (out_hold != 0);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d points outstanding", n_cycles,
                     pending_points.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_step();
        test_zero_radius();
        test_canvas_edges();
        test_extreme_fields();
        test_full_circle();
        test_canvas_settings();
        test_random_circles();
        quiesce();
        $display("Sent %0d transactions (%0d circle starts), checked %0d points",
                 n_items, n_starts, n_points);
        $display("Canvas reprogrammed %0d times, including empty and oversized sizes",
                 n_settings);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/mcr_pkg.sv
src/mcr_state.sv
src/mcr_emit.sv
src/midpoint_circle_rasterizer_top.sv
verif/midpoint_circle_rasterizer_top_tb.sv
